FILE: rtl/core/trt_pkg.sv
// Shared types and constants of the thermistor reading to temperature block.
`timescale 1ns / 1ps

package trt_pkg;

   localparam int CHANNEL_W = 3;
   localparam int BYTE_W = 8;
   localparam int CODE_W = 13;
   localparam int TEMP_W = 13;
   localparam int X_W = 12;
   localparam int P_W = 54;
   localparam int HALF_W = 27;
   localparam int FRAC_SHIFT = 12;
   localparam int OUT_SHIFT = 38;
   localparam int NUM_CELLS = 4;

   localparam logic [CHANNEL_W-1:0] INTERNAL_CHANNEL_DEFAULT = 3'd7;

   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 13'sd4095;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = -13'sd4096;

   localparam logic signed [P_W-1:0] COEF_E = 54'sd372885660352405;
   localparam logic signed [P_W-1:0] COEF_D = -54'sd1817864410012376;
   localparam logic signed [P_W-1:0] COEF_C = 54'sd2313066594594040;
   localparam logic signed [P_W-1:0] COEF_B = -54'sd1535224288230937;
   localparam logic signed [P_W-1:0] COEF_A = 54'sd558640065496793;

   localparam logic signed [P_W-1:0] HORNER_COEF [NUM_CELLS] = '{
      COEF_D, COEF_C, COEF_B, COEF_A
   };

   typedef struct packed {
      logic                     status;
      logic                     internal;
      logic signed [CODE_W-1:0] raw;
   } side_type;

endpackage

FILE: rtl/core/trt_horner_cell.sv
// One Horner step: multiply by the code, scale down and add a coefficient.
`timescale 1ns / 1ps

module trt_horner_cell #(
   parameter logic signed [trt_pkg::P_W-1:0] COEF = trt_pkg::COEF_D
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [trt_pkg::P_W-1:0]   in_p,
   input  trt_pkg::side_type                in_side,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [trt_pkg::P_W-1:0]   out_p,
   output trt_pkg::side_type                out_side
);
   import trt_pkg::*;

   localparam int LO_PROD_W = HALF_W + 1 + X_W + 1;
   localparam int HI_PROD_W = (P_W - HALF_W) + X_W + 1;
   localparam int FULL_W = P_W + X_W + 1;

   logic                        s1_valid_ff;
   logic                        s2_valid_ff;
   logic                        s1_ready;
   logic                        s2_ready;
   logic signed [LO_PROD_W-1:0] prod_lo_in;
   logic signed [HI_PROD_W-1:0] prod_hi_in;
   logic signed [LO_PROD_W-1:0] prod_lo_ff;
   logic signed [HI_PROD_W-1:0] prod_hi_ff;
   side_type                    s1_side_ff;
   logic [FULL_W-1:0]           full_sum;
   logic signed [P_W-1:0]       p_in;
   logic signed [P_W-1:0]       p_ff;
   side_type                    s2_side_ff;
   logic signed [X_W:0]         x_ext;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign x_ext = $signed({1'b0, in_side.raw[X_W-1:0]});
   assign prod_lo_in = $signed({1'b0, in_p[HALF_W-1:0]}) * x_ext;
   assign prod_hi_in = $signed(in_p[P_W-1:HALF_W]) * x_ext;

   // The low partial product is never negative, so it joins by zero extension.
   assign full_sum = {prod_hi_ff, {HALF_W{1'b0}}}
                   + {{(FULL_W - LO_PROD_W){1'b0}}, prod_lo_ff};
   assign p_in = $signed(full_sum[P_W+FRAC_SHIFT-1:FRAC_SHIFT]) + COEF;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         s1_side_ff <= in_side;
      end
      if (s2_ready && s1_valid_ff) begin
         p_ff       <= p_in;
         s2_side_ff <= s1_side_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_p = p_ff;
   assign out_side = s2_side_ff;

endmodule

FILE: rtl/core/trt_output.sv
// Final scaling, saturation, selection of internal and bus error readings, and result register.
`timescale 1ns / 1ps

module trt_output (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [trt_pkg::P_W-1:0]     in_p,
   input  trt_pkg::side_type                  in_side,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_status,
   output logic signed [trt_pkg::CODE_W-1:0]  rsp_raw_code,
   output logic signed [trt_pkg::TEMP_W-1:0]  rsp_temp_sixteenths
);
   import trt_pkg::*;

   localparam int Q_W = P_W - OUT_SHIFT;

   logic                       valid_ff;
   logic                       status_ff;
   logic signed [CODE_W-1:0]   raw_ff;
   logic signed [TEMP_W-1:0]   temp_ff;
   logic signed [P_W-1:0]      p_adj;
   logic signed [Q_W-1:0]      quot;
   logic signed [TEMP_W-1:0]   poly_temp;
   logic signed [TEMP_W-1:0]   temp_in;

   assign in_ready = !valid_ff || rsp_ready;

   // Adding the divisor less one to a negative value makes the shift truncate toward zero.
   assign p_adj = in_p[P_W-1] ? (in_p + $signed({{(P_W - OUT_SHIFT){1'b0}},
                                                {OUT_SHIFT{1'b1}}})) : in_p;
   assign quot = p_adj[P_W-1:OUT_SHIFT];

   always_comb begin
      if (quot > $signed({{(Q_W - TEMP_W){TEMP_MAX[TEMP_W-1]}}, TEMP_MAX})) begin
         poly_temp = TEMP_MAX;
      end else if (quot < $signed({{(Q_W - TEMP_W){TEMP_MIN[TEMP_W-1]}}, TEMP_MIN})) begin
         poly_temp = TEMP_MIN;
      end else begin
         poly_temp = quot[TEMP_W-1:0];
      end
   end

   always_comb begin
      if (in_side.status) begin
         temp_in = '0;
      end else if (in_side.internal) begin
         temp_in = {in_side.raw[TEMP_W-4:0], 3'b000};
      end else begin
         temp_in = poly_temp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         status_ff <= in_side.status;
         raw_ff    <= in_side.raw;
         temp_ff   <= temp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_raw_code = raw_ff;
   assign rsp_temp_sixteenths = temp_ff;

endmodule

FILE: rtl/core/thermistor_reading_to_temperature.sv
// Thermistor reading to temperature: code assembly, Horner cell chain and result stage.
// Path: a transfer passes the s1 and s2 registers of each of the four Horner cells
// and then the result register.
// Throughput: one reading per cycle while results are taken; every stage holds its
// own valid bit and a stalled output only stops the stages that are full.
// Reset clears every valid bit; the data registers are not reset.
`timescale 1ns / 1ps

module thermistor_reading_to_temperature #(
   parameter logic [trt_pkg::CHANNEL_W-1:0] INTERNAL_CHANNEL = trt_pkg::INTERNAL_CHANNEL_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [trt_pkg::CHANNEL_W-1:0]      req_channel,
   input  logic [trt_pkg::BYTE_W-1:0]         req_high_byte,
   input  logic [trt_pkg::BYTE_W-1:0]         req_low_byte,
   input  logic                               req_bus_error,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_status,
   output logic signed [trt_pkg::CODE_W-1:0]  rsp_raw_code,
   output logic signed [trt_pkg::TEMP_W-1:0]  rsp_temp_sixteenths
);
   import trt_pkg::*;

   side_type              side_in;
   logic                  chain_valid [NUM_CELLS+1];
   logic                  chain_ready [NUM_CELLS+1];
   logic signed [P_W-1:0] chain_p     [NUM_CELLS+1];
   side_type              chain_side  [NUM_CELLS+1];

   always_comb begin
      side_in.status = req_bus_error;
      side_in.internal = 1'b0;
      side_in.raw = '0;
      if (!req_bus_error) begin
         if (req_channel == INTERNAL_CHANNEL) begin
            side_in.internal = 1'b1;
            side_in.raw = {{(CODE_W - BYTE_W - 1){req_high_byte[BYTE_W-1]}},
                           req_high_byte, req_low_byte[BYTE_W-1]};
         end else begin
            side_in.raw = {1'b0, req_high_byte, req_low_byte[BYTE_W-1:BYTE_W-4]};
         end
      end
   end

   assign chain_valid[0] = req_valid;
   assign req_ready = chain_ready[0];
   assign chain_p[0] = COEF_E;
   assign chain_side[0] = side_in;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      trt_horner_cell #(
         .COEF(HORNER_COEF[i])
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_p      (chain_p[i]),
         .in_side   (chain_side[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_p     (chain_p[i+1]),
         .out_side  (chain_side[i+1])
      );
   end

   trt_output u_output (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (chain_valid[NUM_CELLS]),
      .in_ready            (chain_ready[NUM_CELLS]),
      .in_p                (chain_p[NUM_CELLS]),
      .in_side             (chain_side[NUM_CELLS]),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_raw_code        (rsp_raw_code),
      .rsp_temp_sixteenths (rsp_temp_sixteenths)
   );

endmodule

FILE: tb/thermistor_reading_to_temperature_test.sv
// Testbench of the thermistor reading to temperature block, checked against its own predictor.
`timescale 1ns / 1ps

module thermistor_reading_to_temperature_test;

   import trt_pkg::*;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_BUS_ERROR = 1'b1;
   localparam int NUM_RANDOM = 1000;
   localparam int NUM_DIRECTED = 20;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic                     status;
      logic signed [CODE_W-1:0] raw;
      logic signed [TEMP_W-1:0] temp;
   } reading_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [BYTE_W-1:0]    high_byte;
      logic [BYTE_W-1:0]    low_byte;
      logic                 bus_error;
      logic                 typed;
      reading_type          expected;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [CHANNEL_W-1:0]     req_channel;
   logic [BYTE_W-1:0]        req_high_byte;
   logic [BYTE_W-1:0]        req_low_byte;
   logic                     req_bus_error;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic                     rsp_status;
   logic signed [CODE_W-1:0] rsp_raw_code;
   logic signed [TEMP_W-1:0] rsp_temp_sixteenths;

   reading_type pending_readings[$];
   int          mismatch_count = 0;
   bit          hold_request = 1'b0;

   // Rows with the typed flag set carry an expectation that is exact by inspection.
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{3'd0, 8'h00, 8'h00, 1'b0, 1'b1, '{STATUS_OK, 13'sd0, 13'sd2032}},
      '{3'd0, 8'h00, 8'h0F, 1'b0, 1'b1, '{STATUS_OK, 13'sd0, 13'sd2032}},
      '{3'd0, 8'hFF, 8'hF0, 1'b0, 1'b0, '0},
      '{3'd0, 8'hFF, 8'hFF, 1'b0, 1'b0, '0},
      '{3'd7, 8'h7F, 8'h80, 1'b0, 1'b1, '{STATUS_OK, 13'sd255, 13'sd2040}},
      '{3'd7, 8'h80, 8'h00, 1'b0, 1'b1, '{STATUS_OK, -13'sd256, -13'sd2048}},
      '{3'd7, 8'hFF, 8'h80, 1'b0, 1'b1, '{STATUS_OK, -13'sd1, -13'sd8}},
      '{3'd7, 8'h00, 8'h00, 1'b0, 1'b1, '{STATUS_OK, 13'sd0, 13'sd0}},
      '{3'd7, 8'h00, 8'h7F, 1'b0, 1'b1, '{STATUS_OK, 13'sd0, 13'sd0}},
      '{3'd1, 8'h80, 8'h00, 1'b0, 1'b0, '0},
      '{3'd2, 8'h12, 8'h34, 1'b0, 1'b0, '0},
      '{3'd3, 8'h55, 8'hAA, 1'b0, 1'b0, '0},
      '{3'd4, 8'hAA, 8'h55, 1'b0, 1'b0, '0},
      '{3'd5, 8'h01, 8'h10, 1'b0, 1'b0, '0},
      '{3'd6, 8'hF0, 8'h0F, 1'b0, 1'b0, '0},
      '{3'd4, 8'h00, 8'h10, 1'b0, 1'b0, '0},
      '{3'd0, 8'h7F, 8'hF0, 1'b0, 1'b0, '0},
      '{3'd0, 8'hFF, 8'hFF, 1'b1, 1'b1, '{STATUS_BUS_ERROR, 13'sd0, 13'sd0}},
      '{3'd7, 8'h80, 8'h80, 1'b1, 1'b1, '{STATUS_BUS_ERROR, 13'sd0, 13'sd0}},
      '{3'd3, 8'h00, 8'h00, 1'b1, 1'b1, '{STATUS_BUS_ERROR, 13'sd0, 13'sd0}}
   };

   thermistor_reading_to_temperature dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_channel         (req_channel),
      .req_high_byte       (req_high_byte),
      .req_low_byte        (req_low_byte),
      .req_bus_error       (req_bus_error),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_raw_code        (rsp_raw_code),
      .rsp_temp_sixteenths (rsp_temp_sixteenths)
   );

   function automatic reading_type convert_reading(logic [CHANNEL_W-1:0] channel,
                                                   logic [BYTE_W-1:0] high_byte,
                                                   logic [BYTE_W-1:0] low_byte,
                                                   logic bus_error);
      reading_type result;
      longint code;
      longint acc;
      longint temp;
      longint coef_e = COEF_E;
      longint coef_d = COEF_D;
      longint coef_c = COEF_C;
      longint coef_b = COEF_B;
      longint coef_a = COEF_A;
      if (bus_error) begin
         result.status = STATUS_BUS_ERROR;
         result.raw = '0;
         result.temp = '0;
         return result;
      end
      if (channel == INTERNAL_CHANNEL_DEFAULT) begin
         code = longint'($signed(high_byte)) * 2 + longint'(low_byte[7]);
         temp = code * 8;
      end else begin
         code = longint'({high_byte, low_byte[7:4]});
         acc = ((coef_e * code) >>> FRAC_SHIFT) + coef_d;
         acc = ((acc * code) >>> FRAC_SHIFT) + coef_c;
         acc = ((acc * code) >>> FRAC_SHIFT) + coef_b;
         acc = ((acc * code) >>> FRAC_SHIFT) + coef_a;
         temp = acc / (longint'(1) <<< OUT_SHIFT);
      end
      if (temp > longint'(TEMP_MAX)) temp = longint'(TEMP_MAX);
      if (temp < longint'(TEMP_MIN)) temp = longint'(TEMP_MIN);
      result.status = STATUS_OK;
      result.raw = code[CODE_W-1:0];
      result.temp = temp[TEMP_W-1:0];
      return result;
   endfunction

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return $urandom_range(1, 3);
      if (pick < 92) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   task automatic offer_reading(logic [CHANNEL_W-1:0] channel, logic [BYTE_W-1:0] high_byte,
                                logic [BYTE_W-1:0] low_byte, logic bus_error,
                                reading_type expected);
      @(negedge clock);
      req_valid <= 1'b1;
      req_channel <= channel;
      req_high_byte <= high_byte;
      req_low_byte <= low_byte;
      req_bus_error <= bus_error;
      do @(posedge clock); while (!req_ready);
      pending_readings.push_back(expected);
   endtask

   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   // Receiver: random stalls and free-running stretches, plus one long hold-off on request.
   initial begin
      int run;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            @(negedge clock);
            if ($urandom_range(0, 99) < 15) begin
               rsp_ready <= 1'b1;
               run = $urandom_range(50, 150);
            end else if ($urandom_range(0, 99) < 65) begin
               rsp_ready <= 1'b1;
               run = idle_length();
            end else begin
               rsp_ready <= 1'b0;
               run = idle_length();
            end
            repeat (run - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      reading_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: result transfer with no expectation waiting", $time);
            mismatch_count++;
         end else begin
            expected = pending_readings.pop_front();
            if (rsp_status !== expected.status) begin
               $display("%0t: status expected %0d got %0d", $time, expected.status,
                        rsp_status);
               mismatch_count++;
            end
            if (rsp_raw_code !== expected.raw) begin
               $display("%0t: raw_code expected %0d got %0d", $time, expected.raw,
                        rsp_raw_code);
               mismatch_count++;
            end
            if (rsp_temp_sixteenths !== expected.temp) begin
               $display("%0t: temp_sixteenths expected %0d got %0d", $time, expected.temp,
                        rsp_temp_sixteenths);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      logic [CHANNEL_W-1:0] channel;
      logic [BYTE_W-1:0] high_byte;
      logic [BYTE_W-1:0] low_byte;
      logic bus_error;
      bit dense;
      int waited;
      reset = 1'b1;
      req_valid = 1'b0;
      req_channel = '0;
      req_high_byte = '0;
      req_low_byte = '0;
      req_bus_error = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         offer_reading(row.channel, row.high_byte, row.low_byte, row.bus_error,
                       row.typed ? row.expected
                                 : convert_reading(row.channel, row.high_byte,
                                                   row.low_byte, row.bus_error));
         if ($urandom_range(0, 1)) pause_sender(idle_length());
      end

      dense = 1'b0;
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i % 64 == 0) dense = $urandom_range(0, 2) == 0;
         // The receiver holds off while the sender keeps offering, so the pipeline fills.
         if (i == 300) hold_request = 1'b1;
         // The sender pauses here until every result has come back.
         if (i == 650) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending_readings.size() != 0) @(posedge clock);
         end
         channel = ($urandom_range(0, 99) < 30) ? INTERNAL_CHANNEL_DEFAULT
                                                 : CHANNEL_W'($urandom_range(0, 7));
         case ($urandom_range(0, 9))
            0: high_byte = 8'h00;
            1: high_byte = 8'hFF;
            2: high_byte = ($urandom_range(0, 1)) ? 8'h80 : 8'h7F;
            default: high_byte = BYTE_W'($urandom_range(0, 255));
         endcase
         low_byte = BYTE_W'($urandom_range(0, 255));
         bus_error = $urandom_range(0, 11) == 0;
         offer_reading(channel, high_byte, low_byte, bus_error,
                       convert_reading(channel, high_byte, low_byte, bus_error));
         if (!dense && !(i >= 300 && i < 340) && $urandom_range(0, 99) >= 55)
            pause_sender(idle_length());
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      waited = 0;
      while (waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
